// File: design/sfdg_pkg.sv
// sfdg_pkg: shared types, codes and constants of the sensor freshness drive gate
// depends on nothing; used by every module in design/

package sfdg_pkg;

  // operation selector carried in tuser
  typedef enum logic [1:0] {
    FUNC_OBSERVE    = 2'd0,
    FUNC_INVALIDATE = 2'd1,
    FUNC_TICK       = 2'd2,
    FUNC_QUERY      = 2'd3
  } func_e;

  // drive decision reported with each result
  typedef enum logic [1:0] {
    MODE_INHIBIT = 2'd0,
    MODE_BRAKE   = 2'd1,
    MODE_RUN     = 2'd2,
    MODE_NO_TICK = 2'd3
  } mode_e;

  // register indexes, byte address is 4 * index
  typedef enum logic [1:0] {
    REG_MAX_AGE   = 2'd0,
    REG_TIMEOUT   = 2'd1,
    REG_RAMP_STEP = 2'd2,
    REG_NONE      = 2'd3
  } reg_e;

  localparam int unsigned PaddrW  = 4;
  localparam int unsigned ItemDataW = 200;
  localparam int unsigned ResDataW  = 56;

  localparam logic [31:0] MaxAgeRst   = 32'd100000;
  localparam logic [15:0] TimeoutRst  = 16'd50;
  localparam logic [14:0] RampStepRst = 15'd64;

  localparam int unsigned WarmupFramesDef = 3;

  // full scale of the speed scale, 1.0 in q1.15
  localparam logic signed [16:0] ScaleOne = 17'sd32768;

  typedef struct packed {
    logic [31:0] max_age_us;
    logic [15:0] timeout_ticks;
    logic [14:0] ramp_step;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        age_ticks;
    logic               started;
    logic               stop;
    logic [31:0]        timeout_total;
    logic               valid;
    logic [1:0]         warmup_count;
    logic [31:0]        last_seq;
    logic [31:0]        obs_time;
    logic [31:0]        obs_epoch;
    logic [31:0]        accept_time;
    logic [15:0]        obs_scale;
    logic signed [15:0] target;
  } state_t;

  typedef struct packed {
    func_e              func;
    logic [31:0]        now_us;
    logic [31:0]        rx_epoch;
    logic [31:0]        seq;
    logic [31:0]        scan_time_us;
    logic [31:0]        epoch;
    logic signed [16:0] scale;
    logic signed [15:0] setpoint;
    logic               reverse;
  } item_t;

  typedef struct packed {
    logic               permitted;
    logic               valid_res;
    logic               started;
    logic               stop_latched;
    logic [31:0]        timeout_count;
    mode_e              drive_mode;
    logic signed [15:0] effective_target;
    logic [1:0]         warmup_level;
  } res_t;

endpackage

// File: design/sfdg_cfg.sv
// sfdg_cfg: apb register file holding max age, timeout and ramp step
// depends on sfdg_pkg

module sfdg_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfdg_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output sfdg_pkg::cfg_t               cfg_o
);

  sfdg_pkg::cfg_t cfg_q, cfg_d;
  sfdg_pkg::reg_e idx;
  logic           wr_en;

  assign idx    = sfdg_pkg::reg_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        sfdg_pkg::REG_MAX_AGE:   cfg_d.max_age_us    = pwdata;
        sfdg_pkg::REG_TIMEOUT:   cfg_d.timeout_ticks = pwdata[15:0];
        sfdg_pkg::REG_RAMP_STEP: cfg_d.ramp_step     = pwdata[14:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      sfdg_pkg::REG_MAX_AGE:   prdata = cfg_q.max_age_us;
      sfdg_pkg::REG_TIMEOUT:   prdata = {16'd0, cfg_q.timeout_ticks};
      sfdg_pkg::REG_RAMP_STEP: prdata = {17'd0, cfg_q.ramp_step};
      default:                 prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_age_us    <= sfdg_pkg::MaxAgeRst;
      cfg_q.timeout_ticks <= sfdg_pkg::TimeoutRst;
      cfg_q.ramp_step     <= sfdg_pkg::RampStepRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: design/sfdg_observe.sv
// sfdg_observe: next state for an offered scan, acceptance checks and warmup count
// depends on sfdg_pkg

module sfdg_observe #(
  parameter int unsigned WarmupFrames = sfdg_pkg::WarmupFramesDef
) (
  input  sfdg_pkg::state_t st_i,
  input  sfdg_pkg::cfg_t   cfg_i,
  input  sfdg_pkg::item_t  item_i,
  output sfdg_pkg::state_t st_o,
  output logic             accepted_o
);

  localparam logic [1:0] WarmupLvl = 2'(WarmupFrames);

  logic [31:0] front_age;
  logic [31:0] accept_gap;
  logic        reject;
  logic        restart;
  logic [1:0]  warm_base;
  logic [1:0]  warm_new;

  assign front_age  = item_i.now_us - item_i.scan_time_us;
  assign accept_gap = item_i.now_us - st_i.accept_time;

  assign reject = st_i.stop || (item_i.epoch != item_i.rx_epoch) ||
                  (front_age > cfg_i.max_age_us) || (item_i.seq == st_i.last_seq);

  // broken sequence or a long gap since the last accepted scan restarts warmup
  assign restart   = (item_i.seq != (st_i.last_seq + 32'd1)) ||
                     (accept_gap > cfg_i.max_age_us);
  assign warm_base = restart ? 2'd0 : st_i.warmup_count;
  assign warm_new  = (warm_base < WarmupLvl) ? warm_base + 2'd1 : warm_base;

  assign accepted_o = ~reject;

  always_comb begin
    st_o = st_i;
    if (reject) begin
      st_o.valid        = 1'b0;
      st_o.warmup_count = 2'd0;
    end else begin
      st_o.last_seq     = item_i.seq;
      st_o.obs_time     = item_i.scan_time_us;
      st_o.obs_epoch    = item_i.epoch;
      st_o.accept_time  = item_i.now_us;
      if (item_i.scale < 17'sd0) begin
        st_o.obs_scale = 16'd0;
      end else if (item_i.scale > sfdg_pkg::ScaleOne) begin
        st_o.obs_scale = sfdg_pkg::ScaleOne[15:0];
      end else begin
        st_o.obs_scale = item_i.scale[15:0];
      end
      st_o.warmup_count = warm_new;
      st_o.valid        = (warm_new >= WarmupLvl);
      if (warm_new >= WarmupLvl) begin
        st_o.age_ticks = 16'd0;
        st_o.started   = 1'b1;
      end
    end
  end

endmodule

// File: design/sfdg_tick.sv
// sfdg_tick: timeout guard, staleness check, drive mode and ramped target for a tick
// depends on sfdg_pkg

module sfdg_tick (
  input  sfdg_pkg::state_t   st_i,
  input  sfdg_pkg::cfg_t     cfg_i,
  input  logic               fresh_i,
  input  logic signed [15:0] setpoint_i,
  input  logic               reverse_i,
  output sfdg_pkg::state_t   st_o,
  output sfdg_pkg::mode_e    mode_o
);

  logic [15:0]        age_new;
  logic               guard;
  logic               stop_new;
  logic               valid_new;
  logic signed [32:0] prod;
  logic signed [17:0] req;
  logic signed [17:0] ceiling;
  logic signed [15:0] run_target;

  assign guard    = st_i.started & ~st_i.stop;
  assign age_new  = (guard && (st_i.age_ticks < cfg_i.timeout_ticks)) ?
                    st_i.age_ticks + 16'd1 : st_i.age_ticks;
  assign stop_new = st_i.stop | (guard & (age_new >= cfg_i.timeout_ticks));
  assign valid_new = st_i.valid & fresh_i;

  // floor(setpoint * scale / 2^15), arithmetic shift floors both signs
  assign prod    = setpoint_i * $signed({1'b0, st_i.obs_scale});
  assign req     = prod[32:15];
  assign ceiling = 18'(st_i.target) + $signed({3'b000, cfg_i.ramp_step});
  assign run_target = (req > ceiling) ? ceiling[15:0] : req[15:0];

  always_comb begin
    st_o           = st_i;
    st_o.age_ticks = age_new;
    st_o.stop      = stop_new;
    if (stop_new && !st_i.stop) begin
      st_o.timeout_total = st_i.timeout_total + 32'd1;
    end
    if (!fresh_i) begin
      st_o.valid        = 1'b0;
      st_o.warmup_count = 2'd0;
    end
    if (!st_i.started || stop_new || !valid_new) begin
      st_o.target = 16'sd0;
      mode_o      = sfdg_pkg::MODE_INHIBIT;
    end else if (reverse_i) begin
      mode_o      = sfdg_pkg::MODE_BRAKE;
    end else begin
      st_o.target = run_target;
      mode_o      = sfdg_pkg::MODE_RUN;
    end
  end

endmodule

// File: design/sensor_freshness_drive_gate.sv
// sensor_freshness_drive_gate: top level, item and result registers plus gate state
// depends on sfdg_pkg, sfdg_cfg, sfdg_observe, sfdg_tick
//
// channel   | dir | handshake                  | payload
// s_axis    | in  | tvalid/tready              | tdata 200 b scan and tick fields, tuser func
// m_axis    | out | tvalid/tready              | tdata 56 b result fields
// apb       | in  | psel/penable/pwrite/pready | paddr 4 b, pwdata/prdata 32 b
//
// one item per clock sustained while m_axis_tready stays high: the input register feeds
// combinational observe/tick logic; the gate state and the result register, which
// holds the report, load together; m_axis_tvalid rises when the item moves from the
// item register into the result register; successive items wait only on m_axis_tready
// rst_ni clears gate state and valid flags at once; config registers return to defaults
// s_axis_tready drops only while both stages are full and m_axis_tready is low

module sensor_freshness_drive_gate #(
  parameter int unsigned WarmupFrames = sfdg_pkg::WarmupFramesDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // scan/tick items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] now_us, [63:32] rx_epoch, [95:64] seq, [127:96] scan_time_us,
  // [159:128] epoch, [176:160] scale, [192:177] setpoint, [193] reverse, rest zero
  input  logic [sfdg_pkg::ItemDataW-1:0]    s_axis_tdata,
  // [1:0] func
  input  logic [1:0]                        s_axis_tuser,
  // results
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] permitted, [1] valid_res, [2] started, [3] stop_latched,
  // [35:4] timeout_count, [37:36] drive_mode, [53:38] effective_target,
  // [55:54] warmup_level
  output logic [sfdg_pkg::ResDataW-1:0]     m_axis_tdata,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sfdg_pkg::PaddrW-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  sfdg_pkg::cfg_t   cfg;
  sfdg_pkg::item_t  item_q, item_d;
  logic             item_vld_q;
  sfdg_pkg::state_t st_q, st_d;
  sfdg_pkg::state_t st_obs, st_tick;
  sfdg_pkg::mode_e  tick_mode;
  sfdg_pkg::res_t   res_q, res_d;
  logic             res_vld_q;
  logic             obs_ok;
  logic             fresh;
  logic             advance;
  logic             take_in;
  logic [31:0]      obs_age;

  sfdg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // the item register moves on whenever the result register is free or draining
  assign advance       = item_vld_q & (~res_vld_q | m_axis_tready);
  assign s_axis_tready = ~item_vld_q | advance;
  assign take_in       = s_axis_tvalid & s_axis_tready;

  always_comb begin
    item_d.func         = sfdg_pkg::func_e'(s_axis_tuser);
    item_d.now_us       = s_axis_tdata[31:0];
    item_d.rx_epoch     = s_axis_tdata[63:32];
    item_d.seq          = s_axis_tdata[95:64];
    item_d.scan_time_us = s_axis_tdata[127:96];
    item_d.epoch        = s_axis_tdata[159:128];
    item_d.scale        = s_axis_tdata[176:160];
    item_d.setpoint     = s_axis_tdata[192:177];
    item_d.reverse      = s_axis_tdata[193];
  end

  // freshness of the stored observation against this item's time and epoch
  assign obs_age = item_q.now_us - st_q.obs_time;
  assign fresh   = (st_q.obs_epoch == item_q.rx_epoch) && (obs_age <= cfg.max_age_us);

  sfdg_observe #(
    .WarmupFrames (WarmupFrames)
  ) u_observe (
    .st_i       (st_q),
    .cfg_i      (cfg),
    .item_i     (item_q),
    .st_o       (st_obs),
    .accepted_o (obs_ok)
  );

  sfdg_tick u_tick (
    .st_i       (st_q),
    .cfg_i      (cfg),
    .fresh_i    (fresh),
    .setpoint_i (item_q.setpoint),
    .reverse_i  (item_q.reverse),
    .st_o       (st_tick),
    .mode_o     (tick_mode)
  );

  always_comb begin
    st_d = st_q;
    case (item_q.func)
      sfdg_pkg::FUNC_OBSERVE: st_d = st_obs;
      sfdg_pkg::FUNC_INVALIDATE: begin
        st_d.valid        = 1'b0;
        st_d.warmup_count = 2'd0;
      end
      sfdg_pkg::FUNC_TICK:    st_d = st_tick;
      sfdg_pkg::FUNC_QUERY:   st_d = st_q;
      default:                st_d = st_q;
    endcase
  end

  // an accepted scan is fresh by its own checks, otherwise the stored one decides
  always_comb begin
    res_d.permitted        = st_d.started & ~st_d.stop & st_d.valid &
                             (((item_q.func == sfdg_pkg::FUNC_OBSERVE) & obs_ok) | fresh);
    res_d.valid_res        = st_d.valid;
    res_d.started          = st_d.started;
    res_d.stop_latched     = st_d.stop;
    res_d.timeout_count    = st_d.timeout_total;
    res_d.drive_mode       = (item_q.func == sfdg_pkg::FUNC_TICK) ?
                             tick_mode : sfdg_pkg::MODE_NO_TICK;
    res_d.effective_target = st_d.target;
    res_d.warmup_level     = st_d.warmup_count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
      st_q       <= '0;
    end else begin
      if (take_in) begin
        item_vld_q <= 1'b1;
      end else if (advance) begin
        item_vld_q <= 1'b0;
      end
      if (advance) begin
        res_vld_q <= 1'b1;
        st_q      <= st_d;
      end else if (m_axis_tready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      item_q <= item_d;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tdata  = {res_q.warmup_level, res_q.effective_target, res_q.drive_mode,
                          res_q.timeout_count, res_q.stop_latched, res_q.started,
                          res_q.valid_res, res_q.permitted};

endmodule
